FILE: rtl/assert_macros.svh
// Assertion macros for the RTL; included by matrix_determinant_top.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/mdet_pkg.sv
// Shared constants for the matrix determinant block.
package mdet_pkg;

    localparam int NUM_PERMS = 24;
    localparam int FRAC_BITS = 8;
    localparam int RES_FRAC_BITS = 32;
    localparam int TAB_ORDER = 4;
    localparam int RESULT_BITS = 64;

    // Permutations of 0..3, lexicographic; nibble r holds the column of row r.
    localparam logic [15:0] PERM_TAB [NUM_PERMS] = '{
        16'h3210, 16'h2310, 16'h3120, 16'h1320, 16'h2130, 16'h1230,
        16'h3201, 16'h2301, 16'h3021, 16'h0321, 16'h2031, 16'h0231,
        16'h3102, 16'h1302, 16'h3012, 16'h0312, 16'h1032, 16'h0132,
        16'h2103, 16'h1203, 16'h2013, 16'h0213, 16'h1023, 16'h0123
    };

    // Odd permutation flags, bit i for table entry i.
    localparam logic [NUM_PERMS-1:0] PERM_ODD = {
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
    };

    function automatic logic [1:0] perm_col(input logic [4:0] idx, input logic [1:0] row);
        logic [15:0] p;
        p = PERM_TAB[idx];
        return p[{row, 2'b00} +: 2];
    endfunction

endpackage

FILE: rtl/mdet_store.sv
// Entry store: one write port, one read port with registered data.
module mdet_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/matrix_determinant_top.sv
// Top level of the matrix determinant block.
// Load: one entry per cycle, n*n requests; the last one starts the evaluation unless a register write comes with it.
// Evaluation: Leibniz sum on one shared multiplier fed by the entry store's read port;
//   the CALC, DRAIN1 and DRAIN2 states follow, and the result is registered in FIN.
// No entry of the next matrix is taken until the result of this one is registered.
// Reset: order register returns to 4, load count to zero, no result pending.
`include "assert_macros.svh"

module matrix_determinant_top #(
    parameter int MAX_ORDER = 4,
    parameter int ENTRY_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            matrix_order,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    matrix_entry,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [63:0]    determinant,
    output logic                  saturated
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PROD_W = 4 * ENTRY_BITS;
    localparam int ACC_W = (PROD_W + 8 > 66) ? PROD_W + 8 : 66;
    localparam int RB = mdet_pkg::RESULT_BITS;

    typedef enum logic [2:0] {LOAD, CALC, DRAIN1, DRAIN2, FIN} state_t;

    state_t            state_reg;
    logic [2:0]        order_reg;
    logic [CW-1:0]     count_reg;
    logic [4:0]        perm_reg;
    logic [1:0]        row_reg;
    logic              rd_valid_reg;
    logic              rd_first_reg;
    logic              rd_neg_reg;
    logic              have_prod_reg;
    logic              out_valid_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [RB-1:0]     det_reg;
    logic                     sat_reg;

    // Effective order: zero counts as one, large values clamp to the maximum.
    logic [2:0] n_eff;
    always_comb
    begin
        priority if (order_reg == 3'd0)
            n_eff = 3'd1;
        else if (order_reg > 3'(MAX_ORDER))
            n_eff = 3'(MAX_ORDER);
        else
            n_eff = order_reg;
    end

    logic [5:0] n_sq;
    assign n_sq = 6'(n_eff) * 6'(n_eff);

    logic in_acc, out_acc, cfg_acc, last_entry;
    assign in_acc     = in_valid && in_ready;
    assign out_acc    = out_valid && out_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign last_entry = in_acc && (6'(count_reg) + 6'd1 == n_sq);

    // A permutation counts only when it fixes every row at or above the order.
    logic perm_ok;
    always_comb
    begin
        perm_ok = 1'b1;
        for (int r = 0; r < mdet_pkg::TAB_ORDER; r++)
        begin
            if (3'(r) >= n_eff && mdet_pkg::perm_col(perm_reg, 2'(r)) != 2'(r))
                perm_ok = 1'b0;
        end
    end

    logic       issue, row_last, perm_last;
    logic [5:0] rd_addr_full;
    assign issue        = (state_reg == CALC) && perm_ok;
    assign row_last     = (3'(row_reg) + 3'd1 == n_eff);
    assign perm_last    = (perm_reg == 5'(mdet_pkg::NUM_PERMS - 1));
    assign rd_addr_full = 6'(row_reg) * 6'(n_eff)
                        + 6'(mdet_pkg::perm_col(perm_reg, row_reg));

    logic [ENTRY_BITS-1:0] rd_data;

    mdet_store #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_BITS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (matrix_entry[ENTRY_BITS-1:0]),
        .rd_en   (issue),
        .rd_addr (rd_addr_full[AW-1:0]),
        .rd_data (rd_data)
    );

    // Result scaling to Q31.32 and saturation check.
    logic signed [ACC_W-1:0] scaled;
    logic                    fits;
    always_comb
    begin
        unique case (n_eff)
            3'd1:    scaled = acc_reg <<< 24;
            3'd2:    scaled = acc_reg <<< 16;
            3'd3:    scaled = acc_reg <<< 8;
            default: scaled = acc_reg;
        endcase
        fits = (scaled[ACC_W-1:RB-1] == '0) || (scaled[ACC_W-1:RB-1] == '1);
    end

    logic finish;
    assign finish = (state_reg == FIN) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LOAD;
            order_reg     <= 3'd4;
            count_reg     <= '0;
            perm_reg      <= '0;
            row_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            have_prod_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cfg_acc)
            begin
                order_reg <= matrix_order;
            end
            // A register write drops the load in progress, even on its last entry.
            if (cfg_acc || last_entry)
                count_reg <= '0;
            else if (in_acc)
                count_reg <= count_reg + 1'b1;
            // A new result may replace the one accepted in the same cycle.
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                LOAD:
                begin
                    if (last_entry && !cfg_acc)
                    begin
                        perm_reg      <= '0;
                        row_reg       <= '0;
                        have_prod_reg <= 1'b0;
                        state_reg     <= CALC;
                    end
                end
                CALC:
                begin
                    if (rd_valid_reg && rd_first_reg)
                        have_prod_reg <= 1'b1;
                    if (!perm_ok || row_last)
                    begin
                        row_reg  <= '0;
                        perm_reg <= perm_reg + 1'b1;
                        if (perm_last)
                            state_reg <= DRAIN1;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                DRAIN1:
                begin
                    if (rd_valid_reg && rd_first_reg)
                        have_prod_reg <= 1'b1;
                    state_reg <= DRAIN2;
                end
                DRAIN2:
                begin
                    have_prod_reg <= 1'b0;
                    state_reg     <= FIN;
                end
                FIN:
                begin
                    if (finish)
                        state_reg <= LOAD;
                end
                default:
                begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end

    // Datapath: product of the current term and the exact running sum.
    logic signed [PROD_W-1:0]            data_ext;
    logic signed [PROD_W+ENTRY_BITS-1:0] mul_full;
    logic signed [ACC_W-1:0]             prod_ext;
    logic                                add_term;
    assign data_ext = PROD_W'($signed(rd_data));
    assign mul_full = prod_reg * $signed(rd_data);
    assign prod_ext = ACC_W'(prod_reg);
    assign add_term = have_prod_reg
                   && ((rd_valid_reg && rd_first_reg) || (state_reg == DRAIN2));

    always_ff @(posedge clk)
    begin
        rd_first_reg <= (row_reg == 2'd0);
        rd_neg_reg   <= mdet_pkg::PERM_ODD[perm_reg];
        if (state_reg == LOAD)
            acc_reg <= '0;
        else if (add_term)
            acc_reg <= prod_neg_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        if (rd_valid_reg)
        begin
            if (rd_first_reg)
            begin
                prod_reg     <= data_ext;
                prod_neg_reg <= rd_neg_reg;
            end
            else
            begin
                prod_reg <= mul_full[PROD_W-1:0];
            end
        end
        if (finish)
        begin
            sat_reg <= !fits;
            if (fits)
                det_reg <= scaled[RB-1:0];
            else if (scaled[ACC_W-1])
                det_reg <= {1'b1, {(RB-1){1'b0}}};
            else
                det_reg <= {1'b0, {(RB-1){1'b1}}};
        end
    end

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == LOAD);
    assign out_valid   = out_valid_reg;
    assign determinant = det_reg;
    assign saturated   = sat_reg;

    // A clamped result carries one of the two range limits.
    `ASSERT_SAME(a_sat_clamp, clk, rst_n, out_valid && saturated,
        (determinant == {1'b1, {(RB-1){1'b0}}}) || (determinant == {1'b0, {(RB-1){1'b1}}}))
    // The last entry of a matrix closes the load side.
    `ASSERT_NEXT(a_last_busy, clk, rst_n, last_entry && !cfg_acc, !in_ready)
    // A register write restarts the load.
    `ASSERT_NEXT(a_cfg_clear, clk, rst_n, cfg_acc, count_reg == '0)
    // Store reads happen only during evaluation.
    `ASSERT_SAME(a_read_calc, clk, rst_n, rd_valid_reg,
        (state_reg == DRAIN1) || (state_reg == CALC))

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the matrix determinant block.
`timescale 1ns / 100ps

module testbench;

    localparam int ORDER_CAP = 4;
    localparam int SETTLE_CYCLES = 150;  // longer than the order-4 turnaround
    localparam int STALL_LIMIT = 4000;   // cycles with no request accepted
    localparam int RANDOM_ENTRIES = 950;

    // One directed case: a register write followed by a run of entries.
    typedef struct {
        logic [2:0]         order;
        int                 n_items;
        logic signed [15:0] e [16];
        bit                 typed;
        logic [63:0]        det;
        bit                 sat;
    } det_case_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            matrix_order;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [15:0]    matrix_entry;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [63:0]    determinant;
    logic                  saturated;

    matrix_determinant_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .matrix_order (matrix_order),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .matrix_entry (matrix_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .determinant  (determinant),
        .saturated    (saturated)
    );

    // Shadow of the block's state, updated on accepted requests.
    logic [2:0]  shadow_order;
    longint      loaded [16];
    int          fill;

    // Expected {saturated, determinant}, oldest first.
    logic [64:0] pending_dets [$];

    // Directed rows with a typed-in answer override the computed one.
    bit          use_typed;
    logic [64:0] typed_det;

    bit          gaps_on;
    int          fail_count;
    int          entries_sent;
    int          dets_checked;
    int          sat_seen;
    int          stall_cycles;

    det_case_t   cases [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int clamp_order(logic [2:0] r);
        if (r == 3'd0)
            return 1;
        if (r > ORDER_CAP)
            return ORDER_CAP;
        return r;
    endfunction

    function automatic longint det3(longint m [9]);
        return m[0] * m[4] * m[8] + m[1] * m[5] * m[6] + m[2] * m[3] * m[7]
             - m[2] * m[4] * m[6] - m[0] * m[5] * m[7] - m[1] * m[3] * m[8];
    endfunction

    // Exact determinant in Q.32, clamped to 64 bits; returns {sat, value}.
    function automatic logic [64:0] matrix_det(int n, longint m [16]);
        logic signed [127:0] acc;
        longint sub [9];
        longint d;
        int k;
        if (n == 1)
            d = m[0] <<< 24;
        else if (n == 2)
            d = (m[0] * m[3] - m[2] * m[1]) <<< 16;
        else if (n == 3)
        begin
            for (int i = 0; i < 9; i++)
                sub[i] = m[i];
            d = det3(sub) <<< 8;
        end
        if (n < 4)
            acc = 128'(signed'(d));
        else
        begin
            // cofactor expansion along the first row
            acc = '0;
            for (int j = 0; j < 4; j++)
            begin
                k = 0;
                for (int r = 1; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (c != j)
                        begin
                            sub[k] = m[r * 4 + c];
                            k++;
                        end
                d = m[j] * det3(sub);
                if (j % 2 == 1)
                    acc = acc - 128'(signed'(d));
                else
                    acc = acc + 128'(signed'(d));
            end
        end
        if (acc > 128'sh7FFF_FFFF_FFFF_FFFF)
            return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
        if (acc < -128'sh8000_0000_0000_0000)
            return {1'b1, 64'h8000_0000_0000_0000};
        return {1'b0, acc[63:0]};
    endfunction

    // Track accepted requests and check results at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [64:0] exp_det;
        if (!rst_n)
        begin
            shadow_order = 3'd4;
            fill = 0;
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                shadow_order = matrix_order;
                fill = 0;   // a partial load is dropped
                stall_cycles = 0;
            end
            if (in_valid && in_ready)
            begin
                loaded[fill] = matrix_entry;
                fill++;
                stall_cycles = 0;
                if (fill == clamp_order(shadow_order) ** 2)
                begin
                    fill = 0;
                    exp_det = use_typed ? typed_det
                                        : matrix_det(clamp_order(shadow_order), loaded);
                    pending_dets.push_back(exp_det);
                end
            end
            if (out_valid && out_ready)
            begin
                stall_cycles = 0;
                if (pending_dets.size() == 0)
                begin
                    $error("determinant result with none expected: %h", determinant);
                    fail_count++;
                end
                else
                begin
                    exp_det = pending_dets.pop_front();
                    dets_checked++;
                    if (saturated)
                        sat_seen++;
                    if (determinant !== exp_det[63:0])
                    begin
                        $error("determinant: expected %h, got %h", exp_det[63:0], determinant);
                        fail_count++;
                    end
                    if (saturated !== exp_det[64])
                    begin
                        $error("saturated: expected %b, got %b", exp_det[64], saturated);
                        fail_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side back-pressure, changed at the falling edge.
    always @(negedge clk)
        out_ready <= !(gaps_on && $urandom_range(99) < 7);

    task automatic send_entry(logic signed [15:0] v);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        matrix_entry <= v;
        do
            @(posedge clk);
        while (!in_ready);
        entries_sent++;
    endtask

    // Wait for the block to drain, then write the order register.
    task automatic write_order(logic [2:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        matrix_order <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_case(logic [2:0] order, int n_items, bit typed,
                                     logic [63:0] det, bit sat,
                                     logic signed [15:0] e [16]);
        det_case_t c;
        c.order = order;
        c.n_items = n_items;
        c.e = e;
        c.typed = typed;
        c.det = det;
        c.sat = sat;
        cases.push_back(c);
    endfunction

    // Mostly full-range values; some extremes to push order 4 into saturation.
    function automatic logic signed [15:0] pick_entry(bit harsh);
        if (harsh)
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh8001;
                default: return 16'(signed'($urandom_range(65535)));
            endcase
        return 16'(signed'($urandom_range(65535)));
    endfunction

    initial
    begin
        logic signed [15:0] e [16];
        logic signed [15:0] hp;
        logic signed [15:0] hn;
        int n;
        int mats;
        bit harsh;
        bit partial_tail;
        int phase;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        matrix_order = 3'd4;
        in_valid = 1'b0;
        matrix_entry = '0;
        out_ready = 1'b1;
        use_typed = 1'b0;
        typed_det = '0;
        gaps_on = 1'b1;
        fail_count = 0;
        entries_sent = 0;
        dets_checked = 0;
        sat_seen = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases.
        e = '{default: 16'sh0000};
        e[0] = 16'sh1234;
        e[1] = 16'sh8000;
        e[2] = 16'sh7FFF;
        add_case(3'd2, 3, 1'b0, '0, 1'b0, e);   // dropped by the next write
        e[0] = 16'sh7FFF;
        add_case(3'd1, 1, 1'b1, 64'h0000_007F_FF00_0000, 1'b0, e);
        e[0] = 16'sh8000;
        add_case(3'd1, 1, 1'b1, 64'hFFFF_FF80_0000_0000, 1'b0, e);
        e[0] = 16'sh0100;
        add_case(3'd0, 1, 1'b1, 64'h0000_0001_0000_0000, 1'b0, e);   // order 0 runs as 1
        e = '{default: 16'sh0000};
        e[0] = 16'sh0100;
        e[3] = 16'sh0100;
        add_case(3'd2, 4, 1'b1, 64'h0000_0001_0000_0000, 1'b0, e);   // identity
        // Hadamard pattern at full scale overflows; order 7 runs as 4
        hp = 16'sh7FFF;
        hn = 16'sh8001;
        e = '{hp, hp, hp, hp,  hp, hn, hp, hn,  hp, hp, hn, hn,  hp, hn, hn, hp};
        add_case(3'd7, 16, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, e);

        foreach (cases[i])
        begin
            write_order(cases[i].order);
            use_typed = cases[i].typed;
            typed_det = {cases[i].sat, cases[i].det};
            for (int k = 0; k < cases[i].n_items; k++)
                send_entry(cases[i].e[k]);
        end
        write_order(3'd4);
        use_typed = 1'b0;

        // Random phases: each picks an order, loads some matrices and may leave
        // a partial one for the next write to drop.
        phase = 0;
        while (entries_sent < RANDOM_ENTRIES)
        begin
            phase++;
            gaps_on = (phase != 4);   // one phase runs with no gaps at all
            write_order(($urandom_range(9) < 5) ? 3'd4 : 3'($urandom_range(7)));
            n = clamp_order(shadow_order);
            mats = gaps_on ? $urandom_range(2, 12) : 12;
            harsh = ($urandom_range(3) == 0);
            partial_tail = ($urandom_range(3) == 0);
            for (int m = 0; m < mats; m++)
                for (int k = 0; k < n * n; k++)
                    send_entry(pick_entry(harsh));
            if (partial_tail && n > 1)
                for (int k = 0; k < $urandom_range(1, n * n - 1); k++)
                    send_entry(pick_entry(harsh));
        end

        // Drain.
        @(negedge clk);
        in_valid <= 1'b0;
        gaps_on = 1'b1;
        while (pending_dets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d entries over %0d phases at orders 0-7; %0d determinants checked,",
                 entries_sent, phase, dets_checked);
        $display("%0d of them saturated.", sat_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
